// File: hdl/idp_pkg.sv
package idp_pkg;

	// result status, numbered by check order
	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_LENGTH      = 4'd1,
		ST_DATE_DELIM  = 4'd2,
		ST_SEPARATOR   = 4'd3,
		ST_TIME_DELIM  = 4'd4,
		ST_NONDIGIT    = 4'd5,
		ST_BAD_DATE    = 4'd6,
		ST_BAD_TIME    = 4'd7,
		ST_ZONE_SHORT  = 4'd8,
		ST_ZONE_COLON  = 4'd9,
		ST_ZONE_MARKER = 4'd10,
		ST_TRAILING    = 4'd11
	} status_t;

	// what was seen at the zone marker position
	typedef enum logic [1:0] {
		ZK_NONE  = 2'd0,
		ZK_Z     = 2'd1,
		ZK_SIGN  = 2'd2,
		ZK_OTHER = 2'd3
	} zone_t;

	// sticky per-position check failures
	typedef struct packed {
		logic date_delim;
		logic separator;
		logic time_delim;
		logic nondigit;
		logic zhour_dig;
		logic zcolon;
		logic zmin_dig;
	} fault_t;

	// parse state; the year is kept as two two-digit halves
	typedef struct packed {
		logic [4:0] count;
		logic [6:0] yhi;
		logic [6:0] ylo;
		logic [6:0] month;
		logic [6:0] day;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		fault_t     faults;
		zone_t      zone;
	} parse_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [26:0] date_number;
	} res_t;

	// days in a month, february without leap day
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2: d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// File: hdl/idp_char_stage.sv
module idp_char_stage
	import idp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output parse_t     snap
);

	localparam logic [4:0] COUNT_MAX = 5'd26;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	parse_t     cur_q;
	logic       dig;
	logic [3:0] dv;

	// two-digit decimal accumulate
	function automatic logic [6:0] acc10(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] t;
		t = 11'(acc) * 11'd10 + 11'(d);
		return t[6:0];
	endfunction

	assign dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dv  = char_code[3:0];

	// per-position check and accumulate
	always_comb begin
		snap = cur_q;
		if (cur_q.count < COUNT_MAX) begin
			snap.count = cur_q.count + 5'd1;
			case (cur_q.count) inside
				5'd4, 5'd7: begin
					if (char_code != CH_DASH) snap.faults.date_delim = 1'b1;
				end
				5'd10: begin
					if (char_code != CH_SPACE && char_code != CH_T)
						snap.faults.separator = 1'b1;
				end
				5'd13, 5'd16: begin
					if (char_code != CH_COLON) snap.faults.time_delim = 1'b1;
				end
				5'd19: begin
					if (char_code == CH_Z) snap.zone = ZK_Z;
					else if (char_code == CH_PLUS || char_code == CH_DASH) snap.zone = ZK_SIGN;
					else snap.zone = ZK_OTHER;
				end
				5'd20, 5'd21: begin
					if (!dig) snap.faults.zhour_dig = 1'b1;
				end
				5'd22: begin
					if (char_code != CH_COLON) snap.faults.zcolon = 1'b1;
				end
				5'd23, 5'd24: begin
					if (!dig) snap.faults.zmin_dig = 1'b1;
				end
				5'd25: begin
				end
				default: begin
					if (!dig) begin
						snap.faults.nondigit = 1'b1;
					end else begin
						case (cur_q.count) inside
							[5'd0:5'd1]:   snap.yhi    = acc10(cur_q.yhi, dv);
							[5'd2:5'd3]:   snap.ylo    = acc10(cur_q.ylo, dv);
							[5'd5:5'd6]:   snap.month  = acc10(cur_q.month, dv);
							[5'd8:5'd9]:   snap.day    = acc10(cur_q.day, dv);
							[5'd11:5'd12]: snap.hour   = acc10(cur_q.hour, dv);
							[5'd14:5'd15]: snap.minute = acc10(cur_q.minute, dv);
							default:       snap.second = acc10(cur_q.second, dv);
						endcase
					end
				end
			endcase
		end
	end

	// parse state, cleared after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			if (last_char) cur_q <= '0;
			else cur_q <= snap;
		end
	end

endmodule

// File: hdl/idp_judge.sv
module idp_judge
	import idp_pkg::*;
(
	input  parse_t snap,
	input  logic   mode,
	output res_t   res
);

	logic       leap;
	logic [4:0] lim;
	logic       date_ok;
	logic       time_ok;
	status_t    st;

	// calendar and time-of-day checks; leap rule from the two year halves
	always_comb begin
		if (snap.ylo == 7'd0) leap = (snap.yhi[1:0] == 2'd0);
		else leap = (snap.ylo[1:0] == 2'd0);
		lim = month_days(snap.month[3:0]);
		if (snap.month == 7'd2 && leap) lim = 5'd29;
		date_ok = (snap.month != 7'd0) && (snap.month <= 7'd12) &&
			(snap.day != 7'd0) && (snap.day <= 7'(lim));
		time_ok = (snap.hour <= 7'd23) && (snap.minute <= 7'd59) &&
			(snap.second <= 7'd59);
	end

	// status, first failing check wins
	always_comb begin
		if (!mode) begin
			if (snap.count != 5'd10 || snap.faults.date_delim) st = ST_LENGTH;
			else if (snap.faults.nondigit) st = ST_NONDIGIT;
			else if (!date_ok) st = ST_BAD_DATE;
			else st = ST_OK;
		end else if (snap.count < 5'd19) begin
			st = ST_LENGTH;
		end else if (snap.faults.date_delim) begin
			st = ST_DATE_DELIM;
		end else if (snap.faults.separator) begin
			st = ST_SEPARATOR;
		end else if (snap.faults.time_delim) begin
			st = ST_TIME_DELIM;
		end else if (snap.faults.nondigit) begin
			st = ST_NONDIGIT;
		end else if (!date_ok) begin
			st = ST_BAD_DATE;
		end else if (!time_ok) begin
			st = ST_BAD_TIME;
		end else if (snap.count == 5'd19) begin
			st = ST_OK;
		end else if (snap.zone == ZK_Z) begin
			st = (snap.count != 5'd20) ? ST_TRAILING : ST_OK;
		end else if (snap.zone == ZK_SIGN) begin
			if (snap.count < 5'd25) st = ST_ZONE_SHORT;
			else if (snap.faults.zhour_dig) st = ST_NONDIGIT;
			else if (snap.faults.zcolon) st = ST_ZONE_COLON;
			else if (snap.faults.zmin_dig) st = ST_NONDIGIT;
			else if (snap.count != 5'd25) st = ST_TRAILING;
			else st = ST_OK;
		end else begin
			st = ST_ZONE_MARKER;
		end
	end

	// fields, zero unless ok
	always_comb begin
		res = '0;
		res.status = st;
		if (st == ST_OK) begin
			res.year  = 14'(snap.yhi) * 14'd100 + 14'(snap.ylo);
			res.month = snap.month[3:0];
			res.day   = snap.day[4:0];
			if (mode) begin
				res.hour   = snap.hour[4:0];
				res.minute = snap.minute[5:0];
				res.second = snap.second[5:0];
			end
			res.date_number = 27'(snap.yhi) * 27'd1000000 + 27'(snap.ylo) * 27'd10000 +
				27'(snap.month) * 27'd100 + 27'(snap.day);
		end
	end

endmodule

// File: hdl/iso_datetime_text_parser.sv
// ISO 8601 date / date-time text parser.
// Input channel: one ASCII character per item on char_code, with last_char
// set on the final character of a string (char_valid / char_stall).
// Output channel: one result item per string, given on its last character
// (res_valid / res_stall): status plus year, month, day, hour, minute,
// second and date_number, all fields zero unless status is ok.
// cfg_we / cfg_data write parse_mode (0 date-only, 1 date-time with optional zone);
// the value held when the last character is taken decides the judgement.
// Throughput: one character per cycle while char_stall is low. The per-character check and the
// decimal accumulate are done in the cycle the character is taken.
// The last character is taken into the snapshot register, and the judged result
// then moves into the result register once that register is free.
// When res_stall holds a result, one more finished string can wait in the
// snapshot register; after that char_stall rises until the result moves.
// Reset clears the parse state and both valid flags and sets parse_mode to 1.
module iso_datetime_text_parser
	import idp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  status,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [26:0] date_number
);

	logic   mode_q;
	logic   char_acc;
	logic   adv;
	parse_t snap;
	parse_t snap_s1;
	logic   mode_s1;
	logic   valid_s1;
	res_t   res;
	res_t   res_q;
	logic   valid_q;

	// handshake
	assign adv        = valid_s1 && (!valid_q || !res_stall);
	assign char_stall = valid_s1 && !adv;
	assign char_acc   = char_valid && !char_stall;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_we) mode_q <= cfg_data;
	end

	idp_char_stage u_char (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (char_acc),
		.char_code (char_code),
		.last_char (last_char),
		.snap      (snap)
	);

	// snapshot of a finished string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (char_acc && last_char) valid_s1 <= 1'b1;
		else if (adv) valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (char_acc && last_char) begin
			snap_s1 <= snap;
			mode_s1 <= mode_q;
		end
	end

	idp_judge u_judge (
		.snap (snap_s1),
		.mode (mode_s1),
		.res  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (adv) valid_q <= 1'b1;
		else if (!res_stall) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

	assign res_valid   = valid_q;
	assign status      = res_q.status;
	assign year        = res_q.year;
	assign month       = res_q.month;
	assign day         = res_q.day;
	assign hour        = res_q.hour;
	assign minute      = res_q.minute;
	assign second      = res_q.second;
	assign date_number = res_q.date_number;

	// a taken last character always lands in the snapshot register
	a_last_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && last_char |=> valid_s1)
		else $error("finished string lost before snapshot");

	// an ok result carries a nonzero month, day and date number
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK |-> month != 4'd0 && day != 5'd0 && date_number != 27'd0)
		else $error("ok result without a date");

	// any failing status clears year, date number and hour
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> year == 14'd0 && date_number == 27'd0 && hour == 5'd0)
		else $error("failing result carries fields");

endmodule

// File: bench/tb_iso_datetime_text_parser.sv
`timescale 1ns / 1ps

module tb_iso_datetime_text_parser;
	import idp_pkg::*;

	// one character offered to the block
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_item_t;

	// scan state of the string being parsed
	typedef struct packed {
		logic [4:0]  count;
		logic [13:0] year;
		logic [6:0]  month, day, hour, minute, second;
		fault_t      faults;
		zone_t       zone;
	} scan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_data = 1'b0;
	logic        char_valid = 1'b0;
	logic [7:0]  char_code = 8'h00;
	logic        last_char = 1'b0;
	logic        res_stall = 1'b0;
	logic        char_stall;
	logic        res_valid;
	logic [3:0]  status;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [26:0] date_number;

	char_item_t pending_chars[$];
	res_t       dates_due[$];
	scan_t      scan = '0;
	bit         datetime_mode = 1'b1;
	bit         char_taken = 1'b0;
	int         chars_pushed = 0;
	int         chars_taken = 0;
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         holds_asked = 0;
	int         holds_done = 0;
	int         hold_left = 0;

	string datetime_cases[] = '{
		"2024-02-29T23:59:59", "0000-01-01 00:00:00Z", "9999-12-31T23:59:59+14:00",
		"1900-02-29T00:00:00", "2000-02-29T12:30:45-05:30",
		"2023-01-01T24:00:00",
		"2023/01-01T00:00:00", "2023-01-01X00:00:00", "2023-01-01T00-00:00",
		"2023-0a-01T00:00:00", "2023-01-01T00:00:00+0",
		"2023-01-01T00:00:00+00-00", "2023-01-01T00:00:00+00:0x",
		"2023-01-01T00:00:00+0x-00", "2023-01-01T00:00:00+00-0x",
		"2023-01-01T00:00:00Q", "2023-01-01T00:00:00Z1",
		"2023-01-01T00:00:00+00:00XXXXX", "2023-01-01"
	};
	string date_cases[] = '{
		"2024-02-29", "2024/02-29", "2024-02-29T", "2023-02-29", "20x3-01-01"
	};

	iso_datetime_text_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.year       (year),
		.month      (month),
		.day        (day),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.date_number(date_number)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// gregorian calendar check
	function automatic bit valid_date(int y, int m, int d);
		int lim;
		if (m < 1 || m > 12)
			return 1'b0;
		case (m)
			2: lim = ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)) ? 29 : 28;
			4, 6, 9, 11: lim = 30;
			default: lim = 31;
		endcase
		return d >= 1 && d <= lim;
	endfunction

	// position check and decimal accumulate for one character
	function automatic void absorb_char(logic [7:0] c);
		bit         is_dig;
		logic [6:0] dv;
		is_dig = (c >= "0" && c <= "9");
		dv = is_dig ? 7'(c - "0") : 7'd0;
		if (scan.count == 5'd26)
			return;
		case (scan.count)
			4, 7: if (c != "-") scan.faults.date_delim = 1'b1;
			10: if (c != " " && c != "T") scan.faults.separator = 1'b1;
			13, 16: if (c != ":") scan.faults.time_delim = 1'b1;
			19: begin
				if (c == "Z")
					scan.zone = ZK_Z;
				else if (c == "+" || c == "-")
					scan.zone = ZK_SIGN;
				else
					scan.zone = ZK_OTHER;
			end
			20, 21: if (!is_dig) scan.faults.zhour_dig = 1'b1;
			22: if (c != ":") scan.faults.zcolon = 1'b1;
			23, 24: if (!is_dig) scan.faults.zmin_dig = 1'b1;
			default: begin
				if (scan.count <= 18) begin
					if (!is_dig)
						scan.faults.nondigit = 1'b1;
					else if (scan.count < 4)
						scan.year = 14'(scan.year * 10 + dv);
					else if (scan.count < 7)
						scan.month = 7'(scan.month * 10 + dv);
					else if (scan.count < 10)
						scan.day = 7'(scan.day * 10 + dv);
					else if (scan.count < 13)
						scan.hour = 7'(scan.hour * 10 + dv);
					else if (scan.count < 16)
						scan.minute = 7'(scan.minute * 10 + dv);
					else
						scan.second = 7'(scan.second * 10 + dv);
				end
			end
		endcase
		scan.count = scan.count + 5'd1;
	endfunction

	// status of the finished string, first failing check wins
	function automatic status_t judge_string();
		int n;
		int zone_end;
		n = scan.count;
		if (!datetime_mode) begin
			if (n != 10 || scan.faults.date_delim)
				return ST_LENGTH;
			if (scan.faults.nondigit)
				return ST_NONDIGIT;
			if (!valid_date(scan.year, scan.month, scan.day))
				return ST_BAD_DATE;
			return ST_OK;
		end
		if (n < 19)
			return ST_LENGTH;
		if (scan.faults.date_delim)
			return ST_DATE_DELIM;
		if (scan.faults.separator)
			return ST_SEPARATOR;
		if (scan.faults.time_delim)
			return ST_TIME_DELIM;
		if (scan.faults.nondigit)
			return ST_NONDIGIT;
		if (!valid_date(scan.year, scan.month, scan.day))
			return ST_BAD_DATE;
		if (scan.hour > 23 || scan.minute > 59 || scan.second > 59)
			return ST_BAD_TIME;
		if (n == 19)
			return ST_OK;
		case (scan.zone)
			ZK_Z: zone_end = 20;
			ZK_SIGN: begin
				if (n < 25)
					return ST_ZONE_SHORT;
				if (scan.faults.zhour_dig)
					return ST_NONDIGIT;
				if (scan.faults.zcolon)
					return ST_ZONE_COLON;
				if (scan.faults.zmin_dig)
					return ST_NONDIGIT;
				zone_end = 25;
			end
			default: return ST_ZONE_MARKER;
		endcase
		if (n != zone_end)
			return ST_TRAILING;
		return ST_OK;
	endfunction

	// expected result of the finished string; the scan starts over
	function automatic res_t close_string();
		res_t r;
		r = '0;
		r.status = judge_string();
		if (r.status == ST_OK) begin
			r.year = scan.year;
			r.month = scan.month[3:0];
			r.day = scan.day[4:0];
			if (datetime_mode) begin
				r.hour = scan.hour[4:0];
				r.minute = scan.minute[5:0];
				r.second = scan.second[5:0];
			end
			r.date_number = 27'(scan.year * 10000 + scan.month * 100 + scan.day);
		end
		scan = '0;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic check_result();
		res_t want;
		if (dates_due.size() == 0) begin
			report_mismatch($sformatf("result with none pending, status %0d", status));
			return;
		end
		want = dates_due.pop_front();
		compare_field("status", status, want.status);
		compare_field("year", year, want.year);
		compare_field("month", month, want.month);
		compare_field("day", day, want.day);
		compare_field("hour", hour, want.hour);
		compare_field("minute", minute, want.minute);
		compare_field("second", second, want.second);
		compare_field("date_number", date_number, want.date_number);
	endtask

	// character driver
	always @(negedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (!char_valid || char_taken) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				char_valid <= 1'b1;
				char_code <= pending_chars[0].code;
				last_char <= pending_chars[0].last;
				void'(pending_chars.pop_front());
			end else begin
				char_valid <= 1'b0;
				char_code <= 8'($urandom_range(255));
				last_char <= 1'($urandom_range(1));
			end
		end
	end

	// result stall, with a long hold-off on request
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done = holds_asked;
			hold_left = 120;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: predict on accepted characters, check accepted results
	always @(posedge clk) begin
		if (!arst_n) begin
			char_taken <= 1'b0;
		end else begin
			char_taken <= char_valid && !char_stall;
			if (char_valid && !char_stall) begin
				chars_taken++;
				absorb_char(char_code);
				if (last_char)
					dates_due.push_back(close_string());
			end
			if (res_valid && !res_stall)
				check_result();
		end
	end

	function automatic void queue_char(logic [7:0] c, bit is_last);
		pending_chars.push_back('{code: c, last: is_last});
		chars_pushed++;
	endfunction

	function automatic void queue_text(string s, bit mark_last);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], mark_last && i == s.len() - 1);
	endfunction

	// random string: mostly well formed, some broken, some noise
	task automatic queue_random_string(bit date_bias);
		logic [7:0] text[$];
		string      s;
		string      sep;
		int         roll, yr, mon, dy, hh, mi, ss, n;
		roll = $urandom_range(99);
		case ($urandom_range(7))
			0: yr = 2000;
			1: yr = 1900;
			2: yr = 2024;
			3: yr = 2100;
			default: yr = $urandom_range(9999);
		endcase
		mon = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
		dy = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31);
		hh = ($urandom_range(9) == 0) ? $urandom_range(24, 99) : $urandom_range(23);
		mi = ($urandom_range(9) == 0) ? $urandom_range(60, 99) : $urandom_range(59);
		ss = ($urandom_range(9) == 0) ? $urandom_range(60, 99) : $urandom_range(59);
		s = $sformatf("%04d-%02d-%02d", yr, mon, dy);
		if (roll >= (date_bias ? 70 : 15)) begin
			sep = $urandom_range(1) ? "T" : " ";
			s = $sformatf("%s%s%02d:%02d:%02d", s, sep, hh, mi, ss);
			case ($urandom_range(3))
				1: s = {s, "Z"};
				2, 3: begin
					sep = $urandom_range(1) ? "+" : "-";
					s = $sformatf("%s%s%02d:%02d", s, sep, $urandom_range(99),
						$urandom_range(99));
				end
				default: ;
			endcase
		end
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		if (roll >= 90) begin
			// raw noise, sometimes past the count limit
			text.delete();
			n = $urandom_range(1, 30);
			repeat (n) text.push_back(8'($urandom_range(255)));
		end else if ($urandom_range(3) == 0) begin
			// one break: bad byte, cut short, or extra bytes
			case ($urandom_range(2))
				0: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
				1: begin
					n = $urandom_range(1, text.size());
					while (text.size() > n)
						void'(text.pop_back());
				end
				default: repeat ($urandom_range(1, 8))
					text.push_back(8'($urandom_range(32, 126)));
			endcase
		end
		foreach (text[i])
			queue_char(text[i], i == text.size() - 1);
	endtask

	// wait until every character is in and every result is out
	task automatic drain();
		while (chars_taken != chars_pushed || dates_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		datetime_mode = v;
	endtask

	// watchdog
	initial begin
		#4_000_000;
		$display("** iso_datetime_text_parser: FAILED **");
		$finish;
	end

	// stimulus sequence
	initial begin
		int strings;
		bit phase_mode;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed date-time strings in the reset mode
		foreach (datetime_cases[i])
			queue_text(datetime_cases[i], 1'b1);
		queue_char(8'h00, 1'b1);
		queue_char(8'hFF, 1'b1);
		drain();

		// directed date-only strings
		write_mode(1'b0);
		foreach (date_cases[i])
			queue_text(date_cases[i], 1'b1);
		drain();

		// mode flipped partway through a string
		queue_text("2024-0", 1'b0);
		drain();
		write_mode(1'b1);
		queue_text("2-29T01:02:03", 1'b1);

		// random phases: long result hold, sender idle, receiver stall, both light
		for (int p = 0; p < 4; p++) begin
			drain();
			phase_mode = (p % 2 == 0);
			write_mode(phase_mode);
			send_idle_pct = (p == 1) ? 78 : (p == 3) ? 16 : 0;
			stall_pct = (p == 2) ? 78 : (p == 3) ? 16 : 0;
			strings = 0;
			while (strings < ((p == 0) ? 3 : 2)) begin
				queue_random_string(!phase_mode);
				strings++;
			end
			if (p == 0)
				holds_asked++;
		end
		drain();
		repeat (20) @(negedge clk);

		if (mismatch_count == 0)
			$display("** iso_datetime_text_parser: PASSED **");
		else
			$display("** iso_datetime_text_parser: FAILED **");
		$finish;
	end

endmodule
